[rtl/pf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types and constants for the Playfair bigram cipher block.
// ----------------------------------------------------------------------------
package pf_pkg;

    localparam int          DATA_W    = 64;
    localparam int          ADDR_W    = 6;
    localparam int          NUM_WORDS = 5;

    localparam logic [7:0]  FILLER    = 8'h58;

    // Register indexes, taken from paddr[5:3].
    localparam logic [2:0]  REG_DIRECTION = 3'd0;
    localparam logic [2:0]  REG_SQUARE_0  = 3'd1;
    localparam logic [2:0]  REG_SQUARE_1  = 3'd2;
    localparam logic [2:0]  REG_SQUARE_2  = 3'd3;
    localparam logic [2:0]  REG_SQUARE_3  = 3'd4;
    localparam logic [2:0]  REG_SQUARE_4  = 3'd5;

    localparam logic [1:0]  ST_OK      = 2'd0;
    localparam logic [1:0]  ST_MISSING = 2'd1;
    localparam logic [1:0]  ST_ODD     = 2'd2;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic       filler;
        logic       fin;
        logic       odd;
    } pf_pair_t;

    typedef struct packed {
        logic [7:0] out_first;
        logic [7:0] out_second;
        logic       filler_used;
        logic       final_pair;
        logic [1:0] status;
    } pf_result_t;

endpackage

[rtl/playfair_bigram_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_bigram_cipher
// Playfair cipher over a configurable square, one text byte per transaction,
// one result transaction per completed pair.
// ----------------------------------------------------------------------------
// A completed pair is held in the pairing register, its result then in the result
// register. Throughput: one input byte per cycle while m_ready is high; both
// registers hold one transaction each and pass a new one every cycle unless m_ready stalls them.
// Reset (synchronous, aresetn low) clears the pending-character flag, both pipeline
// valids, the direction and the square words.
module playfair_bigram_cipher #(
    parameter int SIDE = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pf_pkg::ADDR_W-1:0]  paddr,
    input  logic [pf_pkg::DATA_W-1:0]  pwdata,
    output logic [pf_pkg::DATA_W-1:0]  prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_text_byte,
    input  logic                       s_end_of_message,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_out_first,
    output logic [7:0]                 m_out_second,
    output logic                       m_filler_used,
    output logic                       m_final_pair,
    output logic [1:0]                 m_status
);
    import pf_pkg::*;

    logic              direction_reg;
    logic [DATA_W-1:0] square_word_reg [NUM_WORDS];
    logic [2:0]        reg_index;
    logic [2:0]        word_index;
    logic              cfg_write;
    logic [7:0]        cells [SIDE][SIDE];
    logic              pair_valid;
    logic              pair_ready;
    pf_pair_t          pair;
    pf_result_t        result;
    pf_result_t        out_reg;
    logic              out_valid_reg;

    // Configuration port.
    assign pready     = 1'b1;
    assign reg_index  = paddr[5:3];
    assign word_index = reg_index - 3'd1;
    assign cfg_write  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                square_word_reg[i] <= '0;
            end
        end else if (cfg_write) begin
            unique case (reg_index) inside
                REG_DIRECTION: direction_reg <= pwdata[0];
                REG_SQUARE_0, REG_SQUARE_1, REG_SQUARE_2,
                REG_SQUARE_3, REG_SQUARE_4: square_word_reg[word_index] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index) inside
            REG_DIRECTION: prdata = {{(DATA_W - 1){1'b0}}, direction_reg};
            REG_SQUARE_0, REG_SQUARE_1, REG_SQUARE_2,
            REG_SQUARE_3, REG_SQUARE_4: prdata = square_word_reg[word_index];
            default: prdata = '0;
        endcase
    end

    // Cell i sits in byte (i mod 8) of word (i div 8).
    for (genvar r = 0; r < SIDE; r++) begin : g_row
        for (genvar c = 0; c < SIDE; c++) begin : g_col
            localparam int IDX = r * SIDE + c;
            assign cells[r][c] = square_word_reg[IDX / 8][(IDX % 8) * 8 +: 8];
        end
    end

    pf_pair_stage u_pair (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .dir_decrypt      (direction_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_text_byte      (s_text_byte),
        .s_end_of_message (s_end_of_message),
        .pair_valid       (pair_valid),
        .pair_ready       (pair_ready),
        .pair             (pair)
    );

    pf_transform #(
        .SIDE (SIDE)
    ) u_transform (
        .dir_decrypt (direction_reg),
        .cells       (cells),
        .pair        (pair),
        .result      (result)
    );

    // Result register.
    assign pair_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pair_ready) begin
            out_valid_reg <= pair_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pair_ready && pair_valid) begin
            out_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_first   = out_reg.out_first;
    assign m_out_second  = out_reg.out_second;
    assign m_filler_used = out_reg.filler_used;
    assign m_final_pair  = out_reg.final_pair;
    assign m_status      = out_reg.status;

`ifndef NO_ASSERTIONS
    // An odd-length flag only arises while decrypting.
    a_odd_only_decrypt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_ODD) |-> direction_reg && m_final_pair)
        else $error("odd length status outside decrypt mode");

    // Filler is only inserted while encrypting.
    a_filler_only_encrypt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_filler_used |-> !direction_reg && (m_status != ST_ODD))
        else $error("filler reported in decrypt mode");

    // A character missing from the square zeroes both output characters.
    a_missing_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_MISSING) |-> (m_out_first == 8'h00) &&
                                                (m_out_second == 8'h00))
        else $error("missing character result carries data");
`endif

endmodule

[rtl/pf_pair_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf_pair_stage
// Filters and upper-cases incoming bytes, pairs them through the pending
// character register and registers each completed pair.
// ----------------------------------------------------------------------------
module pf_pair_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              dir_decrypt,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_text_byte,
    input  logic              s_end_of_message,
    output logic              pair_valid,
    input  logic              pair_ready,
    output pf_pkg::pf_pair_t  pair
);
    import pf_pkg::*;

    logic       held_valid_reg;
    logic       held_valid_next;
    logic [7:0] held_char_reg;
    logic       pair_valid_reg;
    pf_pair_t   pair_reg;
    pf_pair_t   pair_next;
    logic       emit;
    logic       accept;
    logic       is_lower;
    logic       keep;
    logic [7:0] ch_up;

    assign is_lower = (s_text_byte >= 8'h61) && (s_text_byte <= 8'h7A);
    assign ch_up    = is_lower ? (s_text_byte - 8'h20) : s_text_byte;
    assign keep     = ((ch_up >= 8'h41) && (ch_up <= 8'h5A)) ||
                      ((ch_up >= 8'h30) && (ch_up <= 8'h39));

    assign s_ready = !pair_valid_reg || pair_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        emit            = 1'b0;
        held_valid_next = held_valid_reg;
        pair_next       = '0;
        if (keep && held_valid_reg) begin
            // A doubled letter in encrypt mode pairs with the filler and
            // the duplicate is consumed.
            emit             = 1'b1;
            held_valid_next  = 1'b0;
            pair_next.first  = held_char_reg;
            pair_next.fin    = s_end_of_message;
            if (!dir_decrypt && (held_char_reg == ch_up)) begin
                pair_next.second = FILLER;
                pair_next.filler = 1'b1;
            end else begin
                pair_next.second = ch_up;
            end
        end else if (s_end_of_message && (keep || held_valid_reg)) begin
            // A lone character closes the message: pad it or flag it.
            emit            = 1'b1;
            held_valid_next = 1'b0;
            pair_next.first = keep ? ch_up : held_char_reg;
            pair_next.fin   = 1'b1;
            if (dir_decrypt) begin
                pair_next.odd = 1'b1;
            end else begin
                pair_next.second = FILLER;
                pair_next.filler = 1'b1;
            end
        end else if (keep) begin
            held_valid_next = 1'b1;
        end else if (s_end_of_message) begin
            held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            pair_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                held_valid_reg <= held_valid_next;
            end
            if (s_ready) begin
                pair_valid_reg <= accept && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && keep && !held_valid_reg) begin
            held_char_reg <= ch_up;
        end
        if (accept && emit) begin
            pair_reg <= pair_next;
        end
    end

    assign pair_valid = pair_valid_reg;
    assign pair       = pair_reg;

`ifndef NO_ASSERTIONS
    // The end of a message always leaves nothing pending.
    a_eom_clears_held: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_end_of_message |=> !held_valid_reg)
        else $error("character still pending after end of message");
`endif

endmodule

[rtl/pf_transform.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf_transform
// Locates both characters of a pair in the square and applies the row,
// column or rectangle rule to form the result.
// ----------------------------------------------------------------------------
module pf_transform #(
    parameter int SIDE = 6
) (
    input  logic               dir_decrypt,
    input  logic [7:0]         cells [SIDE][SIDE],
    input  pf_pkg::pf_pair_t   pair,
    output pf_pkg::pf_result_t result
);
    import pf_pkg::*;

    localparam int RW = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam logic [RW-1:0] LAST = RW'(SIDE - 1);

    logic          found1;
    logic          found2;
    logic [RW-1:0] r1, c1, r2, c2;
    logic [RW-1:0] nr1, nc1, nr2, nc2;

    function automatic logic [RW-1:0] step(input logic [RW-1:0] v, input logic back);
        logic [RW-1:0] res;
        if (back) begin
            res = (v == '0) ? LAST : (v - RW'(1));
        end else begin
            res = (v == LAST) ? '0 : (v + RW'(1));
        end
        return res;
    endfunction

    // Scan from the highest cell down so the lowest matching cell wins.
    always_comb begin
        found1 = 1'b0;
        found2 = 1'b0;
        r1 = '0; c1 = '0; r2 = '0; c2 = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (cells[r][c] == pair.first) begin
                    found1 = 1'b1;
                    r1 = RW'(r);
                    c1 = RW'(c);
                end
                if (cells[r][c] == pair.second) begin
                    found2 = 1'b1;
                    r2 = RW'(r);
                    c2 = RW'(c);
                end
            end
        end
    end

    always_comb begin
        nr1 = r1; nc1 = c1; nr2 = r2; nc2 = c2;
        if (r1 == r2) begin
            nc1 = step(c1, dir_decrypt);
            nc2 = step(c2, dir_decrypt);
        end else if (c1 == c2) begin
            nr1 = step(r1, dir_decrypt);
            nr2 = step(r2, dir_decrypt);
        end else begin
            nc1 = c2;
            nc2 = c1;
        end
    end

    always_comb begin
        result.filler_used = pair.filler;
        result.final_pair  = pair.fin;
        if (pair.odd) begin
            result.out_first   = '0;
            result.out_second  = '0;
            result.filler_used = 1'b0;
            result.status      = ST_ODD;
        end else if (!found1 || !found2) begin
            result.out_first  = '0;
            result.out_second = '0;
            result.status     = ST_MISSING;
        end else begin
            result.out_first  = cells[nr1][nc1];
            result.out_second = cells[nr2][nc2];
            result.status     = ST_OK;
        end
    end

endmodule
